// ===== rtl/core/cso_pkg.sv =====
// shared types and constants for the code span overlap table
// used by cso_cell, cso_chain and code_span_overlap_table; no dependencies
`default_nettype none

package cso_pkg;

  localparam int CAPACITY     = 256;
  localparam int ADDR_WIDTH   = 64;
  localparam int FIELD_W      = 64;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int IN_TDATA_W   = 2 * FIELD_W;
  localparam int OUT_FIELDS_W = 2 * CNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef logic [ADDR_WIDTH-1:0] addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request broadcast to every cell, held for the whole scan
  typedef struct packed {
    logic  is_clear;
    addr_t span_start;
    addr_t span_end;
  } req_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic active;
    logic dup;
    logic found;
    cnt_t count;
  } tok_t;

  // end of request broadcast: settle the pending cell
  typedef struct packed {
    logic go;
    logic commit;
  } fin_t;

endpackage

`default_nettype wire

// ===== rtl/core/cso_cell.sv =====
// one table cell: stores a span and its valid bit, updates the passing scan token
// depends on cso_pkg
`default_nettype none

module cso_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cso_pkg::req_t req,
  input  wire cso_pkg::fin_t fin,
  input  wire cso_pkg::tok_t tok_in,
  output cso_pkg::tok_t      tok_out
);

  cso_pkg::addr_t start_r;
  cso_pkg::addr_t stop_r;
  logic           valid_r, valid_nxt;
  logic           pend_r, pend_nxt;
  cso_pkg::tok_t  tok_r, tok_nxt;

  logic hit_dup, hit_ovl, take, do_clear;

  assign hit_dup  = valid_r && (start_r == req.span_start) && (stop_r == req.span_end);
  assign hit_ovl  = valid_r && (req.span_start < stop_r) && (start_r < req.span_end);
  assign take     = tok_in.active && !req.is_clear && !valid_r && !tok_in.found;
  assign do_clear = tok_in.active && req.is_clear && hit_ovl;

  always_comb begin
    tok_nxt        = tok_in;
    tok_nxt.dup    = tok_in.dup || (tok_in.active && !req.is_clear && hit_dup);
    tok_nxt.found  = tok_in.found || take;
    tok_nxt.count  = tok_in.count + cso_pkg::cnt_t'(do_clear);

    valid_nxt = valid_r;
    if (do_clear) begin
      valid_nxt = 1'b0;
    end else if (fin.go && fin.commit && pend_r) begin
      valid_nxt = 1'b1;
    end

    pend_nxt = pend_r;
    if (take) begin
      pend_nxt = 1'b1;
    end else if (fin.go) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      start_r <= req.span_start;
      stop_r  <= req.span_end;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== rtl/core/cso_chain.sv =====
// row of cso_cell instances with the scan token passed cell to cell
// depends on cso_pkg and cso_cell
`default_nettype none

module cso_chain (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cso_pkg::req_t req,
  input  wire cso_pkg::fin_t fin,
  input  wire cso_pkg::tok_t tok_first,
  output cso_pkg::tok_t      tok_last
);

  cso_pkg::tok_t tok_link [cso_pkg::CAPACITY+1];

  assign tok_link[0] = tok_first;

  for (genvar g = 0; g < cso_pkg::CAPACITY; g++) begin : g_cell
    cso_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req),
      .fin     (fin),
      .tok_in  (tok_link[g]),
      .tok_out (tok_link[g+1])
    );
  end

  assign tok_last = tok_link[cso_pkg::CAPACITY];

endmodule

`default_nettype wire

// ===== rtl/core/code_span_overlap_table.sv =====
// top level of the code span overlap table: stream ports, request control, result register
// depends on cso_pkg and cso_chain
//
// usage
// - in_* carries requests: tuser is the request kind (insert or clear),
//   tdata the span [start, end); a transaction takes place when tvalid and
//   tready are both high at a rising edge
// - out_* carries one result per request: removed count, rejected flag and
//   the number of spans held after the request
// - an insert goes into the lowest free cell; a duplicate, a full table or an
//   empty or inverted span is rejected and changes nothing
// - a clear invalidates every stored span that overlaps the request span
// - a scan token walks the row of cells one cell per cycle; a valid span is
//   registered into the token entering cell 0, then through the token
//   register of each cell, then into the result token and, once the output
//   register is free, into the output register; the next request is taken
//   once back in idle; an empty span skips the scan and waits in the done state
// - one request is in work at a time; in_tready is high while idle, also when
//   a previous result still waits in the output register
// - if the receiver stalls, the finished request holds in the done state and
//   its table commit waits until the output register is free
// - reset (rst_n low, synchronous) empties the table and drops any result
`default_nettype none

module code_span_overlap_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // span_start [63:0], span_end [127:64]
  input  wire logic [cso_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type [0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // removed_count [8:0], rejected [9], entries_in_use [18:10], zero [23:19]
  output logic [cso_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t          state_r, state_nxt;
  cso_pkg::req_t   req_r, req_nxt;
  cso_pkg::tok_t   tok0_r, tok0_nxt;     // token entering cell 0
  cso_pkg::tok_t   res_r, res_nxt;       // final token of the scan
  logic            empty_r, empty_nxt;   // empty or inverted span
  cso_pkg::cnt_t   occ_r, occ_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [cso_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  cso_pkg::tok_t   tok_last;
  cso_pkg::fin_t   fin;
  cso_pkg::addr_t  in_start, in_stop;
  logic            accept, load_out, rej, commit;
  cso_pkg::cnt_t   removed;

  // truncate span fields to the stored address width
  assign in_start = in_tdata[cso_pkg::ADDR_WIDTH-1:0];
  assign in_stop  = in_tdata[cso_pkg::FIELD_W +: cso_pkg::ADDR_WIDTH];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // result of the finished request
  always_comb begin
    if (empty_r) begin
      rej     = 1'b1;
      removed = '0;
    end else if (req_r.is_clear) begin
      rej     = 1'b0;
      removed = res_r.count;
    end else begin
      rej     = res_r.dup || !res_r.found;
      removed = '0;
    end
  end

  assign commit     = !empty_r && !req_r.is_clear && !rej;
  assign fin.go     = load_out;
  assign fin.commit = commit;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tok0_nxt      = '0;
    res_nxt       = res_r;
    empty_nxt     = empty_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt.is_clear   = (in_tuser == cso_pkg::REQ_CLEAR);
          req_nxt.span_start = in_start;
          req_nxt.span_end   = in_stop;
          empty_nxt          = (in_start >= in_stop);
          if (in_start >= in_stop) begin
            // nothing to scan for an empty span
            state_nxt = ST_DONE;
          end else begin
            tok0_nxt.active = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (tok_last.active) begin
          res_nxt   = tok_last;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          if (req_r.is_clear && !empty_r) begin
            occ_nxt = occ_r - removed;
          end else if (commit) begin
            occ_nxt = occ_r + cso_pkg::cnt_t'(1);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = cso_pkg::OUT_TDATA_W'({occ_nxt, rej, removed});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok0_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok0_r      <= tok0_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    empty_r    <= empty_nxt;
    out_data_r <= out_data_nxt;
  end

  cso_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req_r),
    .fin       (fin),
    .tok_first (tok0_r),
    .tok_last  (tok_last)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
